/* hdl/lpvn_pkg.sv */
// ---------------------------------------------------------------------------
// lpvn_pkg: shared types and constants for the Lp vector normalizer
// Widths of the datapath, register indexes, item descriptor and back states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lpvn_pkg;

  localparam int SAMPLE_W = 16;   // Q1.15 sample
  localparam int CNT_W    = 7;    // element count, up to 64
  localparam int ORD_W    = 5;    // clamped norm order, up to 15
  localparam int SUM_W    = 22;   // sum of magnitudes
  localparam int ACC_W    = 40;   // sum of squares
  localparam int NORM_W   = 24;   // norm value
  localparam int DIV_W    = 32;   // divider dividend / quotient
  localparam int SRCH_W   = 19;   // Q16 root search value, up to 2^18
  localparam int SACC_W   = 24;   // sum of Q16 powers
  localparam int PW_W     = 27;   // running Q16 power
  localparam int PADDR_W  = 3;

  localparam logic [SRCH_W-1:0] ONE_Q16  = SRCH_W'(65536);
  localparam logic [SRCH_W-1:0] FOUR_Q16 = SRCH_W'(262144);
  localparam logic [ACC_W-1:0]  SQRT_TOP = ACC_W'(64'h40_0000_0000);

  typedef enum logic {
    REG_NORM_ORDER     = 1'b0,
    REG_ZERO_THRESHOLD = 1'b1
  } reg_idx_t;

  // one loaded vector, handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]    cnt;
    logic [ORD_W-1:0]    ord;
    logic [SAMPLE_W-1:0] mx;
    logic [SUM_W-1:0]    sum;
    logic [ACC_W-1:0]    sq;
  } desc_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQRT, B_T_RD, B_T_WAIT, B_T_DIV, B_T_POW, B_S_CHK, B_S_POW,
    B_N_MUL, B_ZCHK, B_Q_RD, B_Q_WAIT, B_Q_DIV, B_Q_PUSH
  } back_state_t;

  // magnitude of a two's complement sample (most negative maps to 2^15)
  function automatic logic [SAMPLE_W-1:0] mag16(input logic [SAMPLE_W-1:0] s);
    mag16 = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
  endfunction

endpackage
`default_nettype wire

/* hdl/lpvn_queue.sv */
// ---------------------------------------------------------------------------
// lpvn_queue: two-entry descriptor queue
// Decouples the loading front from the computing back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpvn_queue import lpvn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t wdata,
  input  wire logic  pop,
  output desc_t      rdata,
  output logic       full,
  output logic       empty
);
  desc_t      entry [2];
  logic [1:0] level;
  logic       wptr;
  logic       rptr;

  assign rdata = entry[rptr];
  assign full  = level[1];
  assign empty = (level == 2'd0);

  // payload
  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* hdl/lpvn_front.sv */
// ---------------------------------------------------------------------------
// lpvn_front: sample loader
// Stores samples, gathers max / sum / sum of squares, queues a descriptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpvn_front import lpvn_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_ORDER = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [SAMPLE_W-1:0]  sample,
  input  wire logic                 last_in,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire logic [3:0]           norm_order,
  input  wire logic                 q_full,
  output logic                      q_push,
  output desc_t                     q_desc,
  input  wire logic                 release_buf,
  input  wire logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
  output logic [SAMPLE_W-1:0]       rd_data
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [SAMPLE_W-1:0] mem [MAX_LEN];
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W-1:0] mx;
  logic [SUM_W-1:0]    sum;
  logic [ACC_W-1:0]    sq;
  logic                locked;

  logic                take;
  logic                store;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] mx_next;
  logic [SUM_W-1:0]    sum_next;
  logic [ACC_W-1:0]    sq_next;
  logic [ORD_W-1:0]    ord_clamp;

  assign sample_ready = !locked && !q_full;
  assign take  = sample_valid && sample_ready;
  assign store = (cnt < CNT_W'(MAX_LEN));
  assign mag   = mag16(sample);

  // statistics including the current sample
  always_comb begin
    mx_next  = mx;
    sum_next = sum;
    sq_next  = sq;
    if (store) begin
      if (mag > mx) mx_next = mag;
      sum_next = sum + SUM_W'(mag);
      sq_next  = sq + ACC_W'(32'(mag) * 32'(mag));
    end
  end

  assign ord_clamp = (ORD_W'(norm_order) > ORD_W'(MAX_ORDER)) ?
                     ORD_W'(MAX_ORDER) : ORD_W'(norm_order);

  assign q_push     = take && last_in;
  assign q_desc.cnt = cnt + CNT_W'(store);
  assign q_desc.ord = ord_clamp;
  assign q_desc.mx  = mx_next;
  assign q_desc.sum = sum_next;
  assign q_desc.sq  = sq_next;

  // element store, registered read
  always_ff @(posedge clk) begin
    if (take && store) mem[cnt[AW-1:0]] <= sample;
    rd_data <= mem[rd_addr];
  end

  // load control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      mx     <= '0;
      sum    <= '0;
      sq     <= '0;
      locked <= 1'b0;
    end else begin
      if (release_buf) locked <= 1'b0;
      if (take) begin
        if (last_in) begin
          cnt    <= '0;
          mx     <= '0;
          sum    <= '0;
          sq     <= '0;
          locked <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(store);
          mx  <= mx_next;
          sum <= sum_next;
          sq  <= sq_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/lpvn_div.sv */
// ---------------------------------------------------------------------------
// lpvn_div: serial restoring divider
// One quotient bit per cycle; done is high for a single cycle, with the last bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpvn_div import lpvn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [NORM_W-1:0] divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient
);
  logic [NORM_W:0]   rem;
  logic [NORM_W-1:0] dsr;
  logic [5:0]        steps;
  logic              busy;
  logic [NORM_W:0]   shifted;
  logic              fits;

  assign shifted  = {rem[NORM_W-1:0], quotient[DIV_W-1]};
  assign fits     = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= fits ? (shifted - {1'b0, dsr}) : shifted;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 6'(DIV_W);
      end else if (busy) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/lpvn_back.sv */
// ---------------------------------------------------------------------------
// lpvn_back: norm and quotient sequencer
// Finds the chosen order's norm, then divides each element by it or zeroes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpvn_back import lpvn_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire desc_t                q_desc,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire logic [15:0]          zero_threshold,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
  input  wire logic [SAMPLE_W-1:0]  rd_data,
  output logic                      release_buf,
  output logic [SAMPLE_W-1:0]       normalized,
  output logic                      last_out,
  output logic                      zero_norm,
  output logic                      result_valid,
  input  wire logic                 result_ready
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  back_state_t state, state_next;

  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [ORD_W-1:0]    ord, ord_next;
  logic [SAMPLE_W-1:0] mx, mx_next;
  logic [AW-1:0]       idx, idx_next;
  logic [ACC_W-1:0]    v, v_next;
  logic [ACC_W-1:0]    res, res_next;
  logic [ACC_W-1:0]    sbit, sbit_next;
  logic [NORM_W-1:0]   nrm, nrm_next;
  logic                zero, zero_next;
  logic [SACC_W-1:0]   sacc, sacc_next;
  logic [SRCH_W-1:0]   tb, tb_next;
  logic [PW_W-1:0]     pw, pw_next;
  logic [ORD_W-1:0]    k, k_next;
  logic [SRCH_W-1:0]   lo, lo_next;
  logic [SRCH_W-1:0]   hi, hi_next;
  logic [SAMPLE_W-1:0] qv, qv_next;

  logic                ov, ov_next;
  logic [SAMPLE_W-1:0] onorm_next;
  logic                olast_next;
  logic                ozero_next;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [NORM_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;

  logic [NORM_W-1:0]   mul_a;
  logic [SRCH_W-1:0]   mul_b;
  logic [NORM_W+SRCH_W-1:0] prod;
  logic [PW_W-1:0]     prod_sh;
  logic                is_last;

  lpvn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared multiplier: Q16 power steps and final norm scaling
  assign mul_a   = (state == B_N_MUL) ? NORM_W'(mx) : pw[NORM_W-1:0];
  assign mul_b   = (state == B_N_MUL) ? lo : tb;
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod[NORM_W+SRCH_W-1:16];

  assign rd_addr = idx;
  assign is_last = (idx == AW'(cnt - CNT_W'(1)));

  // next state and datapath
  always_comb begin
    logic [SRCH_W-1:0] mid;
    logic              ok;
    logic [DIV_W-1:0]  qs;
    state_next   = state;
    cnt_next     = cnt;
    ord_next     = ord;
    mx_next      = mx;
    idx_next     = idx;
    v_next       = v;
    res_next     = res;
    sbit_next    = sbit;
    nrm_next     = nrm;
    zero_next    = zero;
    sacc_next    = sacc;
    tb_next      = tb;
    pw_next      = pw;
    k_next       = k;
    lo_next      = lo;
    hi_next      = hi;
    qv_next      = qv;
    ov_next      = ov && !result_ready;
    onorm_next   = normalized;
    olast_next   = last_out;
    ozero_next   = zero_norm;
    q_pop        = 1'b0;
    release_buf  = 1'b0;
    div_start    = 1'b0;
    div_dividend = {mag16(rd_data), 16'd0};
    div_divisor  = NORM_W'(mx);
    mid          = lo + ((hi - lo + SRCH_W'(1)) >> 1);
    ok           = 1'b0;
    qs           = div_q;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cnt_next  = q_desc.cnt;
          ord_next  = q_desc.ord;
          mx_next   = q_desc.mx;
          idx_next  = '0;
          sacc_next = '0;
          if (q_desc.ord == ORD_W'(0)) begin
            nrm_next   = NORM_W'(q_desc.mx);
            state_next = B_ZCHK;
          end else if (q_desc.ord == ORD_W'(1)) begin
            nrm_next   = NORM_W'(q_desc.sum);
            state_next = B_ZCHK;
          end else if (q_desc.ord == ORD_W'(2)) begin
            v_next     = q_desc.sq;
            res_next   = '0;
            sbit_next  = SQRT_TOP;
            state_next = B_SQRT;
          end else if (q_desc.mx == '0) begin
            nrm_next   = '0;
            state_next = B_ZCHK;
          end else begin
            state_next = B_T_RD;
          end
        end
      end
      // integer square root, two radicand bits per step
      B_SQRT: begin
        if (sbit != '0) begin
          if (v >= res + sbit) begin
            v_next   = v - (res + sbit);
            res_next = (res >> 1) + sbit;
          end else begin
            res_next = res >> 1;
          end
          sbit_next = sbit >> 2;
        end else begin
          nrm_next   = res[NORM_W-1:0];
          state_next = B_ZCHK;
        end
      end
      B_T_RD: state_next = B_T_WAIT;
      // t = m * 2^16 / max
      B_T_WAIT: begin
        div_start  = 1'b1;
        state_next = B_T_DIV;
      end
      B_T_DIV: begin
        if (div_done) begin
          tb_next    = SRCH_W'(div_q[16:0]);
          pw_next    = PW_W'(div_q[16:0]);
          k_next     = ORD_W'(1);
          state_next = B_T_POW;
        end
      end
      B_T_POW: begin
        if (k == ord) begin
          sacc_next = sacc + pw[SACC_W-1:0];
          if (is_last) begin
            lo_next    = ONE_Q16;
            hi_next    = FOUR_Q16;
            state_next = B_S_CHK;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = B_T_RD;
          end
        end else begin
          pw_next = prod_sh;
          k_next  = k + ORD_W'(1);
        end
      end
      // binary search for the largest root R with R^p <= S
      B_S_CHK: begin
        if (lo < hi) begin
          tb_next    = mid;
          pw_next    = PW_W'(mid);
          k_next     = ORD_W'(1);
          state_next = B_S_POW;
        end else begin
          state_next = B_N_MUL;
        end
      end
      B_S_POW: begin
        if (k == ord || pw > PW_W'(sacc)) begin
          ok = (k == ord) && (pw <= PW_W'(sacc));
          if (ok) lo_next = tb;
          else    hi_next = tb - SRCH_W'(1);
          state_next = B_S_CHK;
        end else begin
          pw_next = prod_sh;
          k_next  = k + ORD_W'(1);
        end
      end
      B_N_MUL: begin
        nrm_next   = prod_sh[NORM_W-1:0];
        state_next = B_ZCHK;
      end
      B_ZCHK: begin
        zero_next  = (nrm <= NORM_W'(zero_threshold));
        idx_next   = '0;
        state_next = B_Q_RD;
      end
      B_Q_RD: state_next = B_Q_WAIT;
      // q = m * 2^15 / N
      B_Q_WAIT: begin
        if (zero) begin
          qv_next    = '0;
          state_next = B_Q_PUSH;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'({mag16(rd_data), 15'd0});
          div_divisor  = nrm;
          state_next   = B_Q_DIV;
        end
      end
      B_Q_DIV: begin
        if (div_done) begin
          if (rd_data[SAMPLE_W-1]) begin
            if (qs > DIV_W'(32768)) qs = DIV_W'(32768);
            qv_next = SAMPLE_W'(0) - qs[SAMPLE_W-1:0];
          end else begin
            if (qs > DIV_W'(32767)) qs = DIV_W'(32767);
            qv_next = qs[SAMPLE_W-1:0];
          end
          state_next = B_Q_PUSH;
        end
      end
      B_Q_PUSH: begin
        if (!ov || result_ready) begin
          ov_next    = 1'b1;
          onorm_next = qv;
          olast_next = is_last;
          ozero_next = zero;
          if (is_last) begin
            release_buf = 1'b1;
            state_next  = B_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = B_Q_RD;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else     ov <= ov_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    ord        <= ord_next;
    mx         <= mx_next;
    idx        <= idx_next;
    v          <= v_next;
    res        <= res_next;
    sbit       <= sbit_next;
    nrm        <= nrm_next;
    zero       <= zero_next;
    sacc       <= sacc_next;
    tb         <= tb_next;
    pw         <= pw_next;
    k          <= k_next;
    lo         <= lo_next;
    hi         <= hi_next;
    qv         <= qv_next;
    normalized <= onorm_next;
    last_out   <= olast_next;
    zero_norm  <= ozero_next;
  end

  assign result_valid = ov;
endmodule
`default_nettype wire

/* hdl/lp_vector_normalize.sv */
// ---------------------------------------------------------------------------
// lp_vector_normalize: Lp-norm vector normalizer
// Loads a Q1.15 vector, finds its norm, emits each element over the norm.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle, while sample_ready is high, until last_in;
// up to MAX_LEN are kept and the rest are dropped. The norm is then found by
// the back sequencer: orders 0 and 1 directly, order 2 by a serial square
// root, order p of 3 or more by per-element ratios and then a root search.
// Every result then goes through the store read and the 32-step serial
// divider; a vector whose norm is at or below the threshold skips the
// divider. A new vector is taken once the last result of the previous one
// has been produced; config writes go through the APB port at addresses 0
// and 4.
`timescale 1ns / 1ps
`default_nettype none
module lp_vector_normalize import lpvn_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_ORDER = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic signed [15:0]   sample,
  input  wire logic                 last_in,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  output logic signed [15:0]        normalized,
  output logic                      last_out,
  output logic                      zero_norm,
  output logic                      result_valid,
  input  wire logic                 result_ready
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [3:0]          norm_order;
  logic [15:0]         zero_threshold;
  logic                cfg_wr;
  reg_idx_t            reg_sel;

  logic                q_push, q_pop, q_full, q_empty;
  desc_t               q_wdata, q_rdata;
  logic                release_buf;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] norm_u;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_order     <= 4'd2;
      zero_threshold <= 16'd1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_NORM_ORDER:     norm_order     <= pwdata[3:0];
        REG_ZERO_THRESHOLD: zero_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NORM_ORDER:     prdata = {28'd0, norm_order};
      REG_ZERO_THRESHOLD: prdata = {16'd0, zero_threshold};
      default:            prdata = '0;
    endcase
  end

  lpvn_front #(.MAX_LEN(MAX_LEN), .MAX_ORDER(MAX_ORDER)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .last_in      (last_in),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .norm_order   (norm_order),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_wdata),
    .release_buf  (release_buf),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  lpvn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lpvn_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_desc         (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .zero_threshold (zero_threshold),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .release_buf    (release_buf),
    .normalized     (norm_u),
    .last_out       (last_out),
    .zero_norm      (zero_norm),
    .result_valid   (result_valid),
    .result_ready   (result_ready)
  );

  assign normalized = $signed(norm_u);
endmodule
`default_nettype wire

/* hdl/lpvn_checker.sv */
// ---------------------------------------------------------------------------
// lpvn_checker: port-level checks for the normalizer
// Watches the result channel and the config port over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpvn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pready,
  input wire logic [15:0] normalized,
  input wire logic        zero_norm,
  input wire logic        result_valid,
  input wire logic        result_ready
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(normalized))
    else $error("stalled result changed");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a zero-norm vector gives zero elements
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_norm |-> normalized == 16'd0)
    else $error("zero norm with nonzero element");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind lp_vector_normalize lpvn_checker u_lpvn_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .normalized   (normalized),
  .zero_norm    (zero_norm),
  .result_valid (result_valid),
  .result_ready (result_ready)
);
`default_nettype wire
